>>> design/es2fat_pkg.sv
`timescale 1ns / 1ps
// Package for the seconds-to-FAT-timestamp converter: pipeline depth, reciprocal
// constants for the fixed divisions and the month start table.
// No dependencies.
package es2fat_pkg;

   localparam int NUM_STAGES = 10;

   // floor(x / d) = (x * MUL) >> SHIFT, exact over the value ranges used here
   localparam logic [31:0] DIV60_MUL   = 32'h8888_8889;
   localparam int          DIV60_SHIFT = 37;
   localparam logic [31:0] DIV24_MUL   = 32'hAAAA_AAAB;
   localparam int          DIV24_SHIFT = 36;
   localparam logic [29:0] DIV7_MUL    = 30'd613566757;
   localparam logic [21:0] DIV1461_MUL = 22'd2939745;

   // days are counted from 1968-01-01 so that four-year cycles start on a leap year
   localparam logic [15:0] EPOCH_SHIFT_DAYS = 16'd731;
   // days since 1970 of 2100-03-01; from there on skip the absent 29 February 2100
   localparam logic [15:0] SKIP_LEAP_DAY    = 16'd47541;
   localparam logic [15:0] CYCLE_DAYS       = 16'd1461;
   localparam logic [10:0] YEAR1_START      = 11'd366;
   localparam logic [10:0] YEAR2_START      = 11'd731;
   localparam logic [10:0] YEAR3_START      = 11'd1096;
   localparam logic [7:0]  FAT_YEAR_BASE    = 8'd10;
   localparam logic [3:0]  MONTH_LAST       = 4'd11;

   localparam logic [8:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // first day of month idx (0 = January) within the year, from 0
   function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
      logic [8:0] start;
      start = 9'd0;
      if (idx <= MONTH_LAST) begin
         start = MONTH_START[idx];
         if (leap && idx >= 4'd2) begin
            start = start + 9'd1;
         end
      end
      return start;
   endfunction

endpackage

>>> design/epoch_seconds_to_fat_timestamp.sv
`timescale 1ns / 1ps
// Converts seconds since 1970 into calendar fields and a packed FAT date/time word.
// Depends on es2fat_pkg.
//
// Pipeline: ten register stages, 0 to 9; rsp_valid is the valid bit of the last one.
// Throughput: one transfer per cycle while req_stall is low; a stage holds one item
// and moves on when the stage after it is free, so a stall on rsp_ backs up only
// as far as needed.
// Reset clears all stage valid bits; the data path is not reset.
module epoch_seconds_to_fat_timestamp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_second,
   output logic [5:0]  rsp_minute,
   output logic [4:0]  rsp_hour,
   output logic [2:0]  rsp_weekday,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month,
   output logic [7:0]  rsp_years_since_1970,
   output logic [31:0] rsp_fat_stamp,
   output logic        rsp_before_1980
);

   localparam int LAST = es2fat_pkg::NUM_STAGES - 1;

   logic [LAST:0] vld_ff, vld_in;
   logic [LAST:0] adv;

   // stage 0
   logic [31:0] t0_ff, t0_in;
   logic [63:0] p1_ff, p1_in;
   // stage 1
   logic [26:0] q1_ff, q1_in;
   logic [58:0] p2_ff, p2_in;
   logic [5:0]  sec1_in;
   // stage 2
   logic [20:0] q2_ff, q2_in;
   logic [52:0] p3_ff, p3_in;
   logic [5:0]  min2_in;
   // stage 3
   logic [15:0] days3_ff, days3_in;
   logic [4:0]  hour3_in;
   // stage 4
   logic [15:0] dw4_ff, dw4_in;
   logic [15:0] dd4_ff, dd4_in;
   // stage 5
   logic [45:0] pw5_ff, pw5_in;
   logic [37:0] py5_ff, py5_in;
   logic [15:0] dw5_ff;
   logic [15:0] dd5_ff;
   // stage 6
   logic [5:0]  y4_ff, y4_in;
   logic [10:0] r6_ff, r6_in;
   logic [2:0]  wday6_in;
   // stage 7
   logic [7:0]  year7_ff, year7_in;
   logic [8:0]  doy7_ff, doy7_in;
   logic        leap7_ff, leap7_in;
   // stage 8
   logic [7:0]  year8_ff;
   logic [3:0]  month8_ff, month8_in;
   logic [4:0]  mday8_ff, mday8_in;
   // stage 9 (output register)
   logic [7:0]  year9_ff;
   logic [3:0]  month9_ff;
   logic [4:0]  mday9_ff;
   logic [31:0] fat9_ff, fat9_in;
   logic        early9_ff, early9_in;

   // time fields carried down the pipe
   logic [5:0]  sec_ff  [1:LAST];
   logic [5:0]  min_ff  [2:LAST];
   logic [4:0]  hour_ff [3:LAST];
   logic [2:0]  wday_ff [6:LAST];

   // per-stage advance: a stage loads when it is empty or its contents move on
   always_comb begin
      adv[LAST] = !vld_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i + 1];
      end
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int i = 1; i <= LAST; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i - 1] : vld_ff[i];
      end
   end

   assign req_stall = !adv[0];

   // seconds, minutes, hours, whole days
   always_comb begin
      t0_in    = req_seconds;
      p1_in    = 64'(req_seconds) * 64'(es2fat_pkg::DIV60_MUL);

      q1_in    = p1_ff[63:es2fat_pkg::DIV60_SHIFT];
      sec1_in  = 6'(t0_ff - 32'(q1_in) * 32'd60);
      p2_in    = 59'(q1_in) * 59'(es2fat_pkg::DIV60_MUL);

      q2_in    = p2_ff[57:es2fat_pkg::DIV60_SHIFT];
      min2_in  = 6'(q1_ff - 27'(q2_in) * 27'd60);
      p3_in    = 53'(q2_in) * 53'(es2fat_pkg::DIV24_MUL);

      days3_in = p3_ff[51:es2fat_pkg::DIV24_SHIFT];
      hour3_in = 5'(q2_ff - 21'(days3_in) * 21'd24);
   end

   // weekday and year split
   always_comb begin
      dw4_in = days3_ff + 16'd4;
      dd4_in = days3_ff + es2fat_pkg::EPOCH_SHIFT_DAYS
             + ((days3_ff >= es2fat_pkg::SKIP_LEAP_DAY) ? 16'd1 : 16'd0);

      pw5_in = 46'(dw4_ff) * 46'(es2fat_pkg::DIV7_MUL);
      py5_in = 38'(dd4_ff) * 38'(es2fat_pkg::DIV1461_MUL);

      wday6_in = 3'(dw5_ff - 16'(pw5_ff[44:32]) * 16'd7) + 3'd1;
      y4_in    = py5_ff[37:32];
      r6_in    = 11'(dd5_ff - 16'(y4_in) * es2fat_pkg::CYCLE_DAYS);
   end

   // year within the four-year cycle, day of year, then month and day
   always_comb begin
      logic [1:0] yic;
      logic [3:0] mon;
      if (r6_ff < es2fat_pkg::YEAR1_START) begin
         yic     = 2'd0;
         doy7_in = 9'(r6_ff);
      end else if (r6_ff < es2fat_pkg::YEAR2_START) begin
         yic     = 2'd1;
         doy7_in = 9'(r6_ff - es2fat_pkg::YEAR1_START);
      end else if (r6_ff < es2fat_pkg::YEAR3_START) begin
         yic     = 2'd2;
         doy7_in = 9'(r6_ff - es2fat_pkg::YEAR2_START);
      end else begin
         yic     = 2'd3;
         doy7_in = 9'(r6_ff - es2fat_pkg::YEAR3_START);
      end
      // cycles start in 1968, hence minus two
      year7_in = {y4_ff, yic} - 8'd2;
      leap7_in = (yic == 2'd0);

      mon = 4'd0;
      for (int k = 1; k <= 11; k++) begin
         if (doy7_ff >= es2fat_pkg::month_start(4'(k), leap7_ff)) begin
            mon = 4'(k);
         end
      end
      month8_in = mon + 4'd1;
      mday8_in  = 5'(doy7_ff - es2fat_pkg::month_start(mon, leap7_ff) + 9'd1);

      early9_in = (year8_ff < es2fat_pkg::FAT_YEAR_BASE);
      fat9_in   = {early9_in ? 7'd0 : 7'(year8_ff - es2fat_pkg::FAT_YEAR_BASE),
                   month8_ff, mday8_ff, hour_ff[8], min_ff[8], sec_ff[8][5:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         t0_ff <= t0_in;
         p1_ff <= p1_in;
      end
      if (adv[1]) begin
         q1_ff     <= q1_in;
         p2_ff     <= p2_in;
         sec_ff[1] <= sec1_in;
      end
      if (adv[2]) begin
         q2_ff     <= q2_in;
         p3_ff     <= p3_in;
         min_ff[2] <= min2_in;
      end
      if (adv[3]) begin
         days3_ff   <= days3_in;
         hour_ff[3] <= hour3_in;
      end
      if (adv[4]) begin
         dw4_ff <= dw4_in;
         dd4_ff <= dd4_in;
      end
      if (adv[5]) begin
         pw5_ff <= pw5_in;
         py5_ff <= py5_in;
         dw5_ff <= dw4_ff;
         dd5_ff <= dd4_ff;
      end
      if (adv[6]) begin
         y4_ff      <= y4_in;
         r6_ff      <= r6_in;
         wday_ff[6] <= wday6_in;
      end
      if (adv[7]) begin
         year7_ff <= year7_in;
         doy7_ff  <= doy7_in;
         leap7_ff <= leap7_in;
      end
      if (adv[8]) begin
         year8_ff  <= year7_ff;
         month8_ff <= month8_in;
         mday8_ff  <= mday8_in;
      end
      if (adv[9]) begin
         year9_ff  <= year8_ff;
         month9_ff <= month8_ff;
         mday9_ff  <= mday8_ff;
         fat9_ff   <= fat9_in;
         early9_ff <= early9_in;
      end
      for (int i = 2; i <= LAST; i++) begin
         if (adv[i]) begin
            sec_ff[i] <= sec_ff[i - 1];
         end
      end
      for (int i = 3; i <= LAST; i++) begin
         if (adv[i]) begin
            min_ff[i] <= min_ff[i - 1];
         end
      end
      for (int i = 4; i <= LAST; i++) begin
         if (adv[i]) begin
            hour_ff[i] <= hour_ff[i - 1];
         end
      end
      for (int i = 7; i <= LAST; i++) begin
         if (adv[i]) begin
            wday_ff[i] <= wday_ff[i - 1];
         end
      end
   end

   assign rsp_valid            = vld_ff[LAST];
   assign rsp_second           = sec_ff[LAST];
   assign rsp_minute           = min_ff[LAST];
   assign rsp_hour             = hour_ff[LAST];
   assign rsp_weekday          = wday_ff[LAST];
   assign rsp_day_of_month     = mday9_ff;
   assign rsp_month            = month9_ff;
   assign rsp_years_since_1970 = year9_ff;
   assign rsp_fat_stamp        = fat9_ff;
   assign rsp_before_1980      = early9_ff;

endmodule
